@@ rtl/rcd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rcd_pkg
// Shared types, opcodes and constants of the CAT command decoder.
// ----------------------------------------------------------------------------
package rcd_pkg;

    localparam int S_TDATA_W   = 80;
    localparam int M_TDATA_W   = 80;
    localparam int M_TUSER_W   = 3;
    localparam int FREQ_ACC_W  = 28;
    localparam int FREQ_W      = 31;
    localparam int EFF_VAL_W   = 30;
    localparam int FRAME_CNT_W = 4;
    localparam int BYTE_CNT_W  = 3;

    localparam logic [FRAME_CNT_W-1:0] MAX_FRAMES    = 4'd12;
    localparam logic [BYTE_CNT_W-1:0]  FRAME_BYTES   = 3'd5;
    localparam logic [FREQ_W-1:0]      FREQ_MAX      = 31'd999999990;
    localparam logic [31:0]            TIMEOUT_RESET = 32'd1000;

    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_SERVICE = 1'b1;

    localparam logic [7:0] OP_SET_FREQ   = 8'h01;
    localparam logic [7:0] OP_SPLIT_ON   = 8'h02;
    localparam logic [7:0] OP_GET_FREQ   = 8'h03;
    localparam logic [7:0] OP_SET_MODE   = 8'h07;
    localparam logic [7:0] OP_PTT_ON     = 8'h08;
    localparam logic [7:0] OP_TOGGLE_VFO = 8'h81;
    localparam logic [7:0] OP_SPLIT_OFF  = 8'h82;
    localparam logic [7:0] OP_PTT_OFF    = 8'h88;
    localparam logic [7:0] OP_READ_TX    = 8'hF7;

    localparam logic [7:0] REPLY_ACK      = 8'h00;
    localparam logic [7:0] REPLY_PTT_SAME = 8'hF0;
    localparam logic [7:0] TX_STATUS_INIT = 8'hFF;
    localparam logic [7:0] TX_MASK        = 8'h7F;
    localparam logic [7:0] SPLIT_MASK     = 8'hDF;

    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_SHORT = 3'd1;
    localparam logic [2:0] LEN_FULL  = 3'd5;

    typedef enum logic [2:0] {
        EFF_NONE  = 3'd0,
        EFF_FREQ  = 3'd1,
        EFF_MODE  = 3'd2,
        EFF_SPLIT = 3'd3,
        EFF_VFO   = 3'd4,
        EFF_PTT   = 3'd5
    } effect_t;

    typedef struct packed {
        logic                  store_byte;
        logic                  latch_svc;
        logic                  conn_set;
        logic                  conn_clr;
        logic                  clear_ring;
        logic                  rd_issue;
        logic                  rd_capture;
        logic [BYTE_CNT_W-1:0] cap_idx;
        logic                  out_load;
        logic                  out_last;
    } rcd_cmd_t;

    typedef struct packed {
        logic link_up;
        logic was_connected;
        logic timed_out;
        logic frame_ready;
        logic out_free;
    } rcd_status_t;

endpackage
`default_nettype wire

@@ rtl/rcd_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rcd_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module rcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ rtl/rcd_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rcd_ctrl
// Sequencer: takes items, decides each service call and walks the frames.
// ----------------------------------------------------------------------------
module rcd_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic                s_tuser,
    input  wire rcd_pkg::rcd_status_t status,
    output rcd_pkg::rcd_cmd_t        cmd
);

    import rcd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_READ,
        S_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [FRAME_CNT_W-1:0] frame_cnt_reg, frame_cnt_next;
    logic [BYTE_CNT_W-1:0]  byte_cnt_reg, byte_cnt_next;
    logic                   last_frame;

    assign last_frame = (frame_cnt_reg == MAX_FRAMES - 4'd1) || !status.frame_ready;

    always_comb begin
        cmd            = '0;
        s_tready       = 1'b0;
        state_next     = state_reg;
        frame_cnt_next = frame_cnt_reg;
        byte_cnt_next  = byte_cnt_reg;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == ACT_SERVICE) begin
                        cmd.latch_svc = 1'b1;
                        state_next    = S_EVAL;
                    end else begin
                        cmd.store_byte = 1'b1;
                    end
                end
            end
            S_EVAL: begin
                frame_cnt_next = '0;
                byte_cnt_next  = '0;
                if (!status.link_up) begin
                    cmd.conn_clr = 1'b1;
                    state_next   = S_IDLE;
                end else if (!status.was_connected) begin
                    cmd.clear_ring = 1'b1;
                    cmd.conn_set   = 1'b1;
                    state_next     = S_IDLE;
                end else if (status.timed_out) begin
                    cmd.clear_ring = 1'b1;
                    state_next     = S_IDLE;
                end else if (status.frame_ready) begin
                    state_next = S_READ;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_READ: begin
                cmd.rd_issue   = (byte_cnt_reg < FRAME_BYTES);
                cmd.rd_capture = (byte_cnt_reg != '0);
                cmd.cap_idx    = byte_cnt_reg - 3'd1;
                byte_cnt_next  = byte_cnt_reg + 3'd1;
                if (byte_cnt_reg == FRAME_BYTES) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load  = 1'b1;
                    cmd.out_last  = last_frame;
                    byte_cnt_next = '0;
                    if (last_frame) begin
                        frame_cnt_next = '0;
                        state_next     = S_IDLE;
                    end else begin
                        frame_cnt_next = frame_cnt_reg + 4'd1;
                        state_next     = S_READ;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            frame_cnt_reg <= '0;
            byte_cnt_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            frame_cnt_reg <= frame_cnt_next;
            byte_cnt_reg  <= byte_cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_frame_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_cnt_reg < MAX_FRAMES)
        else $error("frame counter beyond the per-call limit");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> status.out_free)
        else $error("result loaded over a pending word");

    a_read_only_in_service: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.rd_issue |-> !s_tready)
        else $error("ring read while taking input");
`endif

endmodule
`default_nettype wire

@@ rtl/rcd_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rcd_datapath
// Ring buffer, time stamp, link flag, frame decode and the result register.
// ----------------------------------------------------------------------------
module rcd_datapath #(
    parameter int RING_DEPTH = 64
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_we,
    input  wire logic [31:0]                     cfg_wdata,
    input  wire logic [rcd_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire rcd_pkg::rcd_cmd_t               cmd,
    output rcd_pkg::rcd_status_t                 status,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [rcd_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic      [rcd_pkg::M_TUSER_W-1:0]   m_tuser,
    output logic                                 m_tlast
);

    import rcd_pkg::*;

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(RING_DEPTH - 1);
    localparam logic [IDX_W:0]   DEPTH_L  = (IDX_W + 1)'(RING_DEPTH);
    localparam logic [IDX_W:0]   MIN_FILL = (IDX_W + 1)'(5);

    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next, rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] wr_idx_inc, rd_idx_inc;
    logic [IDX_W:0]   fill;
    logic             full, do_write;
    logic [31:0]      stamp_reg, stamp_next, timeout_reg;
    logic             conn_reg;

    logic [31:0] now_reg, freq_bcd_reg;
    logic        link_reg, tx_reg, split_reg;
    logic [3:0]  mode_reg;

    logic [7:0]            rd_data;
    logic [7:0]            frame_reg [5];
    logic [FREQ_ACC_W-1:0] acc_reg;
    logic [7:0]            byte_val;
    logic [FREQ_W-1:0]     freq_full;

    logic [2:0]           len_d;
    logic [7:0]           r0_d, r1_d, r2_d, r3_d, r4_d;
    effect_t              eff_d;
    logic [EFF_VAL_W-1:0] val_d;

    logic                 out_valid_reg, out_last_reg;
    logic [2:0]           out_len_reg;
    logic [7:0]           out_b0_reg, out_b1_reg, out_b2_reg, out_b3_reg, out_b4_reg;
    effect_t              out_eff_reg;
    logic [EFF_VAL_W-1:0] out_val_reg;

    assign wr_idx_inc = (wr_idx_reg == LAST_IDX) ? '0 : wr_idx_reg + IDX_W'(1);
    assign rd_idx_inc = (rd_idx_reg == LAST_IDX) ? '0 : rd_idx_reg + IDX_W'(1);
    assign full       = (wr_idx_inc == rd_idx_reg);
    assign do_write   = cmd.store_byte && !full;
    assign fill       = (wr_idx_reg >= rd_idx_reg)
                      ? {1'b0, wr_idx_reg} - {1'b0, rd_idx_reg}
                      : DEPTH_L - {1'b0, rd_idx_reg} + {1'b0, wr_idx_reg};

    always_comb begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        stamp_next  = stamp_reg;
        if (do_write) begin
            wr_idx_next = wr_idx_inc;
            stamp_next  = s_tdata[40:9];
        end
        if (cmd.clear_ring) begin
            wr_idx_next = '0;
            rd_idx_next = '0;
            stamp_next  = now_reg;
        end else if (cmd.rd_issue) begin
            rd_idx_next = rd_idx_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg  <= '0;
            rd_idx_reg  <= '0;
            stamp_reg   <= '0;
            conn_reg    <= 1'b0;
            timeout_reg <= TIMEOUT_RESET;
        end else begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            stamp_reg  <= stamp_next;
            if (cmd.conn_set) begin
                conn_reg <= 1'b1;
            end else if (cmd.conn_clr) begin
                conn_reg <= 1'b0;
            end
            if (cfg_we) begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    rcd_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (do_write),
        .wr_addr (wr_idx_reg),
        .wr_data (s_tdata[7:0]),
        .rd_en   (cmd.rd_issue),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (cmd.latch_svc) begin
            link_reg     <= s_tdata[8];
            now_reg      <= s_tdata[40:9];
            tx_reg       <= s_tdata[41];
            split_reg    <= s_tdata[42];
            mode_reg     <= s_tdata[46:43];
            freq_bcd_reg <= s_tdata[78:47];
        end
    end

    assign byte_val = (8'(rd_data[7:4]) * 8'd10) + 8'(rd_data[3:0]);

    always_ff @(posedge aclk) begin
        if (cmd.rd_capture) begin
            case (cmd.cap_idx)
                3'd0: frame_reg[0] <= rd_data;
                3'd1: frame_reg[1] <= rd_data;
                3'd2: frame_reg[2] <= rd_data;
                3'd3: frame_reg[3] <= rd_data;
                default: frame_reg[4] <= rd_data;
            endcase
            if (cmd.cap_idx == 3'd0) begin
                acc_reg <= FREQ_ACC_W'(byte_val);
            end else if (cmd.cap_idx < 3'd4) begin
                acc_reg <= FREQ_ACC_W'(acc_reg * FREQ_ACC_W'(100)) + FREQ_ACC_W'(byte_val);
            end
        end
    end

    assign freq_full = FREQ_W'(acc_reg) * FREQ_W'(10);

    always_comb begin
        len_d = LEN_SHORT;
        r0_d  = REPLY_ACK;
        r1_d  = 8'h00;
        r2_d  = 8'h00;
        r3_d  = 8'h00;
        r4_d  = 8'h00;
        eff_d = EFF_NONE;
        val_d = '0;
        case (frame_reg[4])
            OP_SET_FREQ: begin
                eff_d = EFF_FREQ;
                val_d = (freq_full > FREQ_MAX) ? EFF_VAL_W'(FREQ_MAX) : EFF_VAL_W'(freq_full);
            end
            OP_GET_FREQ: begin
                len_d = LEN_FULL;
                r0_d  = freq_bcd_reg[7:0];
                r1_d  = freq_bcd_reg[15:8];
                r2_d  = freq_bcd_reg[23:16];
                r3_d  = freq_bcd_reg[31:24];
                r4_d  = {4'h0, mode_reg};
            end
            OP_SET_MODE: begin
                eff_d = EFF_MODE;
                val_d = EFF_VAL_W'(frame_reg[0]);
            end
            OP_SPLIT_ON: begin
                eff_d = EFF_SPLIT;
                val_d = EFF_VAL_W'(1);
            end
            OP_SPLIT_OFF: begin
                eff_d = EFF_SPLIT;
            end
            OP_TOGGLE_VFO: begin
                eff_d = EFF_VFO;
            end
            OP_PTT_ON: begin
                eff_d = EFF_PTT;
                val_d = EFF_VAL_W'(1);
                r0_d  = tx_reg ? REPLY_PTT_SAME : REPLY_ACK;
            end
            OP_PTT_OFF: begin
                eff_d = EFF_PTT;
                r0_d  = tx_reg ? REPLY_ACK : REPLY_PTT_SAME;
            end
            OP_READ_TX: begin
                r0_d = TX_STATUS_INIT & (tx_reg ? TX_MASK : 8'hFF)
                                      & (split_reg ? SPLIT_MASK : 8'hFF);
            end
            default: begin
                len_d = LEN_NONE;
                r0_d  = 8'h00;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_len_reg  <= len_d;
            out_b0_reg   <= r0_d;
            out_b1_reg   <= r1_d;
            out_b2_reg   <= r2_d;
            out_b3_reg   <= r3_d;
            out_b4_reg   <= r4_d;
            out_eff_reg  <= eff_d;
            out_val_reg  <= val_d;
            out_last_reg <= cmd.out_last;
        end
    end

    assign status.link_up       = link_reg;
    assign status.was_connected = conn_reg;
    assign status.timed_out     = (now_reg - stamp_reg) >= timeout_reg;
    assign status.frame_ready   = (fill >= MIN_FILL);
    assign status.out_free      = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = M_TUSER_W'(out_eff_reg);
    assign m_tdata  = {7'd0, out_val_reg, out_b4_reg, out_b3_reg, out_b2_reg,
                       out_b1_reg, out_b0_reg, out_len_reg};

`ifndef NO_ASSERTIONS
    a_len_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_len_reg == LEN_NONE || out_len_reg == LEN_SHORT
                           || out_len_reg == LEN_FULL))
        else $error("reply length outside the defined set");

    a_no_value_without_effect: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_eff_reg == EFF_NONE || out_eff_reg == EFF_VFO)
        |-> out_val_reg == '0)
        else $error("effect value given without an effect that uses it");

    a_read_idx_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.store_byte || cmd.latch_svc) |=> $stable(rd_idx_reg))
        else $error("read index moved while taking input");
`endif

endmodule
`default_nettype wire

@@ rtl/radio_cat_command_decoder.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// radio_cat_command_decoder
// Buffers received bytes and decodes five-byte CAT frames on service calls.
// ----------------------------------------------------------------------------
//  Channel  Ports               Carries
//  input    s_tvalid/s_tready   received byte or service call (s_tuser)
//  result   m_tvalid/m_tready   reply bytes and radio effect per frame
//  config   cfg_we/cfg_wdata    idle timeout, no read-back
//
//  Bytes are taken when idle; a service call is evaluated before new input. Each
//  frame is five ring reads through the registered RAM port, each byte captured
//  from its output, then one load of the result register; at most twelve frames
//  are decoded per call. A stalled result holds the sequencer in place.
//  Synchronous active-low reset clears indexes, stamp and connected flag at once.
// ----------------------------------------------------------------------------
module radio_cat_command_decoder #(
    parameter int RING_DEPTH = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [31:0]                   cfg_wdata,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // rx_byte, link_up, now_time, radio_is_tx, radio_split, radio_mode, radio_freq_bcd
    input  wire logic [rcd_pkg::S_TDATA_W-1:0] s_tdata,
    // action
    input  wire logic                          s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // reply_len, reply_b0, reply_b1, reply_b2, reply_b3, reply_b4, effect_value
    output logic      [rcd_pkg::M_TDATA_W-1:0] m_tdata,
    // effect
    output logic      [rcd_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                               m_tlast
);

    import rcd_pkg::*;

    rcd_cmd_t    cmd;
    rcd_status_t status;

    rcd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    rcd_datapath #(
        .RING_DEPTH (RING_DEPTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the CAT command decoder: received bytes and service
// calls go in on the slave stream, decoded replies are checked against a
// cycle-free model of the ring buffer, link tracking, timeout and decoding.
// ----------------------------------------------------------------------------
module testbench;
    import rcd_pkg::*;

    localparam int RING_SLOTS  = 64;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_WORDS = 25;

    localparam logic [7:0] CAT_OPS [9] = '{OP_SET_FREQ, OP_SPLIT_ON, OP_GET_FREQ,
        OP_SET_MODE, OP_PTT_ON, OP_TOGGLE_VFO, OP_SPLIT_OFF, OP_PTT_OFF, OP_READ_TX};

    typedef struct packed {
        logic        act;
        logic [7:0]  rx;
        logic        link;
        logic [31:0] now;
        logic        tx;
        logic        split;
        logic [3:0]  mode;
        logic [31:0] bcd;
    } cat_word_t;

    typedef struct packed {
        logic [2:0]  len;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [7:0]  b3;
        logic [7:0]  b4;
        effect_t     eff;
        logic [29:0] val;
        logic        last;
    } cat_reply_t;

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_FRAME,
        ROW_CALL
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [7:0]  op;
        logic [31:0] args;
        logic [31:0] now;
        logic        link;
        logic        tx;
        logic        split;
        logic [3:0]  mode;
        logic [31:0] bcd;
        logic        chk;
        cat_reply_t  want;
    } script_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_we;
    logic [31:0]          cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    logic [7:0]  ring_mem [RING_SLOTS];
    logic [5:0]  ring_wr = '0;
    logic [5:0]  ring_rd = '0;
    logic [31:0] ring_stamp = '0;
    logic        linked = 1'b0;
    logic [31:0] idle_limit = TIMEOUT_RESET;

    cat_reply_t  awaited_replies [$];
    cat_reply_t  typed_reply;
    bit          typed_on = 1'b0;
    script_row_t script [$];

    int          send_idle_pct = 25;
    int          recv_idle_pct = 51;
    int          words_sent = 0;
    int          fault_count = 0;
    int          cycles = 0;
    logic [31:0] clock_now = '0;
    cat_reply_t  got_reply;

    radio_cat_command_decoder #(
        .RING_DEPTH(RING_SLOTS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic cat_reply_t cat_decode_frame(input logic [4:0][7:0] frm,
                                                    input cat_word_t w);
        cat_reply_t  r;
        logic [31:0] khz;
        r = '0;
        r.len = LEN_SHORT;
        khz = '0;
        case (frm[4])
            OP_SET_FREQ: begin
                for (int k = 0; k < 4; k++) begin
                    khz = khz * 100 + frm[k][7:4] * 10 + frm[k][3:0];
                end
                khz = khz * 10;
                if (khz > FREQ_MAX) begin
                    khz = 32'(FREQ_MAX);
                end
                r.eff = EFF_FREQ;
                r.val = khz[29:0];
            end
            OP_GET_FREQ: begin
                r.len = LEN_FULL;
                {r.b3, r.b2, r.b1, r.b0} = w.bcd;
                r.b4 = {4'd0, w.mode};
            end
            OP_SET_MODE: begin
                r.eff = EFF_MODE;
                r.val = 30'(frm[0]);
            end
            OP_SPLIT_ON: begin
                r.eff = EFF_SPLIT;
                r.val = 30'd1;
            end
            OP_SPLIT_OFF: begin
                r.eff = EFF_SPLIT;
            end
            OP_TOGGLE_VFO: begin
                r.eff = EFF_VFO;
            end
            OP_PTT_ON: begin
                r.eff = EFF_PTT;
                r.val = 30'd1;
                r.b0 = w.tx ? REPLY_PTT_SAME : REPLY_ACK;
            end
            OP_PTT_OFF: begin
                r.eff = EFF_PTT;
                r.b0 = !w.tx ? REPLY_PTT_SAME : REPLY_ACK;
            end
            OP_READ_TX: begin
                r.b0 = TX_STATUS_INIT;
                if (w.tx) begin
                    r.b0 = r.b0 & TX_MASK;
                end
                if (w.split) begin
                    r.b0 = r.b0 & SPLIT_MASK;
                end
            end
            default: begin
                r.len = LEN_NONE;
            end
        endcase
        return r;
    endfunction

    // Advances the model by one accepted word and queues the replies it causes.
    task automatic track_word(input cat_word_t w);
        cat_reply_t       batch [12];
        logic [4:0][7:0]  frm;
        logic [5:0]       fill;
        int               n;
        n = 0;
        fill = ring_wr - ring_rd;
        if (w.act == ACT_BYTE) begin
            if (ring_wr + 6'd1 != ring_rd) begin
                ring_mem[ring_wr] = w.rx;
                ring_wr = ring_wr + 6'd1;
                ring_stamp = w.now;
            end
        end else if (!w.link) begin
            linked = 1'b0;
        end else if (!linked || (w.now - ring_stamp >= idle_limit)) begin
            ring_wr = '0;
            ring_rd = '0;
            ring_stamp = w.now;
            linked = 1'b1;
        end else begin
            while (n < MAX_FRAMES && fill >= 6'd5) begin
                for (int k = 0; k < 5; k++) begin
                    frm[k] = ring_mem[ring_rd];
                    ring_rd = ring_rd + 6'd1;
                end
                batch[n] = cat_decode_frame(frm, w);
                fill = ring_wr - ring_rd;
                n++;
            end
            for (int i = 0; i < n; i++) begin
                batch[i].last = (i == n - 1);
                awaited_replies.push_back(typed_on ? typed_reply : batch[i]);
            end
        end
    endtask

    task automatic report_fault(input string what, input cat_reply_t want,
                                input cat_reply_t got);
        fault_count++;
        if (fault_count <= 10) begin
            $display("%s at cycle %0d", what, cycles);
            $display("  expected %p", want);
            $display("  actual   %p", got);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_reply.len  = m_tdata[2:0];
            got_reply.b0   = m_tdata[10:3];
            got_reply.b1   = m_tdata[18:11];
            got_reply.b2   = m_tdata[26:19];
            got_reply.b3   = m_tdata[34:27];
            got_reply.b4   = m_tdata[42:35];
            got_reply.val  = m_tdata[72:43];
            got_reply.eff  = effect_t'(m_tuser);
            got_reply.last = m_tlast;
            if (awaited_replies.size() == 0) begin
                report_fault("reply word with nothing expected", '0, got_reply);
            end else if (got_reply.len !== awaited_replies[0].len
                    || got_reply.b0 !== awaited_replies[0].b0
                    || got_reply.b1 !== awaited_replies[0].b1
                    || got_reply.b2 !== awaited_replies[0].b2
                    || got_reply.b3 !== awaited_replies[0].b3
                    || got_reply.b4 !== awaited_replies[0].b4
                    || got_reply.eff !== awaited_replies[0].eff
                    || got_reply.val !== awaited_replies[0].val
                    || got_reply.last !== awaited_replies[0].last) begin
                report_fault("reply word mismatch", awaited_replies.pop_front(), got_reply);
            end else begin
                void'(awaited_replies.pop_front());
            end
        end
    end

    function automatic cat_word_t rand_word();
        cat_word_t w;
        w.act   = 1'($urandom_range(1));
        w.rx    = 8'($urandom_range(255));
        w.link  = 1'($urandom_range(1));
        w.now   = $urandom;
        w.tx    = 1'($urandom_range(1));
        w.split = 1'($urandom_range(1));
        w.mode  = 4'($urandom_range(15));
        w.bcd   = $urandom;
        return w;
    endfunction

    function automatic cat_reply_t ack_reply(input effect_t eff, input logic [29:0] val);
        cat_reply_t r;
        r = '0;
        r.len  = LEN_SHORT;
        r.b0   = REPLY_ACK;
        r.eff  = eff;
        r.val  = val;
        r.last = 1'b1;
        return r;
    endfunction

    // The valid line is only raised here, so a held valid never sees a second
    // assignment in the step of its handshake.
    task automatic send_word(input cat_word_t w);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w.act;
        s_tdata  <= {1'b0, w.bcd, w.mode, w.split, w.tx, w.now, w.link, w.rx};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        track_word(w);
    endtask

    task automatic send_frame(input logic [7:0] op, input logic [31:0] args,
                              input cat_word_t base);
        cat_word_t w;
        w = base;
        w.act = ACT_BYTE;
        for (int k = 0; k < 4; k++) begin
            w.rx = args[31 - 8 * k -: 8];
            send_word(w);
        end
        w.rx = op;
        send_word(w);
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (awaited_replies.size() != 0);
    endtask

    task automatic set_timeout(input logic [31:0] value);
        s_tvalid <= 1'b0;
        wait_drained();
        repeat (20) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        idle_limit = value;
    endtask

    task automatic add_row(input row_kind_t kind, input logic [7:0] op,
                           input logic [31:0] args, input logic [31:0] now,
                           input logic link, input logic tx, input logic split,
                           input logic [3:0] mode, input logic [31:0] bcd);
        script_row_t r;
        r = '0;
        r.kind  = kind;
        r.op    = op;
        r.args  = args;
        r.now   = now;
        r.link  = link;
        r.tx    = tx;
        r.split = split;
        r.mode  = mode;
        r.bcd   = bcd;
        script.push_back(r);
    endtask

    task automatic add_check(input cat_reply_t want);
        script[$].chk  = 1'b1;
        script[$].want = want;
    endtask

    task automatic random_burst(input bit fill_ring, input bit squeeze);
        cat_word_t   w;
        int          frames;
        int          pick;
        logic [7:0]  op;
        logic [31:0] args;
        logic [31:0] delta;
        logic [31:0] span;
        if ($urandom_range(11) == 0) begin
            w = rand_word();
            w.act  = ACT_SERVICE;
            w.link = 1'b0;
            send_word(w);
            w = rand_word();
            w.act  = ACT_SERVICE;
            w.link = 1'b1;
            send_word(w);
        end else begin
            if (fill_ring) begin
                frames = 13;
            end else if ($urandom_range(14) == 0) begin
                frames = $urandom_range(13, 8);
            end else begin
                frames = $urandom_range(3);
            end
            for (int f = 0; f < frames; f++) begin
                pick = $urandom_range(9);
                op = (pick == 9) ? 8'($urandom) : CAT_OPS[pick];
                args = $urandom;
                if (op == OP_SET_FREQ && $urandom_range(1) == 1) begin
                    for (int d = 0; d < 8; d++) begin
                        args[4 * d +: 4] = 4'($urandom_range(9));
                    end
                end
                clock_now = ($urandom_range(19) == 0) ? $urandom
                                                      : clock_now + $urandom_range(5);
                w = rand_word();
                w.now = clock_now;
                send_frame(op, args, w);
            end
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(4, 1)) begin
                    w = rand_word();
                    w.act = ACT_BYTE;
                    w.now = clock_now;
                    send_word(w);
                end
            end
            if (squeeze || $urandom_range(7) == 0) begin
                s_tvalid <= 1'b0;
                wait_drained();
            end
            if ($urandom_range(3) != 0) begin
                span = (idle_limit - 32'd1 < 32'd300) ? idle_limit - 32'd1 : 32'd300;
                delta = $urandom_range(span);
            end else if (idle_limit > 32'hFFFF_FFF0) begin
                delta = idle_limit;
            end else begin
                delta = idle_limit + $urandom_range(3);
            end
            w = rand_word();
            w.act  = ACT_SERVICE;
            w.link = ($urandom_range(15) != 0);
            w.now  = ring_stamp + delta;
            send_word(w);
        end
    endtask

    task automatic run_phase(input logic [31:0] timeout, input int tx_idle,
                             input int rx_idle, input bit fill_ring);
        int start;
        int burst;
        set_timeout(timeout);
        send_idle_pct = tx_idle;
        recv_idle_pct = rx_idle;
        start = words_sent;
        burst = 0;
        while (words_sent - start < PHASE_WORDS) begin
            random_burst(fill_ring && burst == 1, burst == 0);
            burst++;
        end
    endtask

    initial begin
        cat_word_t  w;
        cat_reply_t freq_reply;
        aresetn   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= ACT_BYTE;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        freq_reply = '{len: LEN_FULL, b0: 8'h78, b1: 8'h56, b2: 8'h34, b3: 8'h12,
                       b4: 8'h0F, eff: EFF_NONE, val: 30'd0, last: 1'b1};
        add_row(ROW_CALL,  8'h00,         32'h0,        32'd0,    0, 0, 0, 4'h0, 32'h0);
        add_row(ROW_CALL,  8'h00,         32'h0,        32'd5,    1, 0, 0, 4'h0, 32'h0);
        add_row(ROW_FRAME, OP_SET_FREQ,   32'h99999999, 32'd10,   1, 0, 0, 4'h0, 32'h0);
        add_row(ROW_CALL,  8'h00,         32'h0,        32'd20,   1, 0, 0, 4'h0, 32'h0);
        add_check(ack_reply(EFF_FREQ, 30'd999999990));
        add_row(ROW_FRAME, OP_SET_FREQ,   32'hFFFFFFFF, 32'd30,   1, 0, 0, 4'h0, 32'h0);
        add_row(ROW_CALL,  8'h00,         32'h0,        32'd40,   1, 0, 0, 4'h0, 32'h0);
        add_check(ack_reply(EFF_FREQ, 30'd999999990));
        add_row(ROW_FRAME, OP_SET_FREQ,   32'h00000000, 32'd50,   1, 0, 0, 4'h0, 32'h0);
        add_row(ROW_CALL,  8'h00,         32'h0,        32'd60,   1, 0, 0, 4'h0, 32'h0);
        add_check(ack_reply(EFF_FREQ, 30'd0));
        add_row(ROW_FRAME, OP_GET_FREQ,   32'h12345678, 32'd70,   1, 0, 0, 4'h0, 32'h0);
        add_row(ROW_CALL,  8'h00,         32'h0,        32'd80,   1, 0, 0, 4'hF, 32'h12345678);
        add_check(freq_reply);
        add_row(ROW_FRAME, OP_SET_MODE,   32'hFF000000, 32'd90,   1, 0, 0, 4'h0, 32'h0);
        add_row(ROW_CALL,  8'h00,         32'h0,        32'd100,  1, 0, 0, 4'h0, 32'h0);
        add_check(ack_reply(EFF_MODE, 30'd255));
        add_row(ROW_FRAME, OP_SPLIT_ON,   32'h0,        32'd110,  1, 0, 0, 4'h0, 32'h0);
        add_row(ROW_FRAME, OP_SPLIT_OFF,  32'h0,        32'd120,  1, 0, 0, 4'h0, 32'h0);
        add_row(ROW_FRAME, OP_TOGGLE_VFO, 32'h0,        32'd130,  1, 0, 0, 4'h0, 32'h0);
        add_row(ROW_FRAME, OP_PTT_ON,     32'h0,        32'd140,  1, 0, 0, 4'h0, 32'h0);
        add_row(ROW_FRAME, OP_PTT_OFF,    32'h0,        32'd150,  1, 0, 0, 4'h0, 32'h0);
        add_row(ROW_FRAME, OP_READ_TX,    32'h0,        32'd160,  1, 0, 0, 4'h0, 32'h0);
        add_row(ROW_FRAME, 8'h5A,         32'hA5A5A5A5, 32'd170,  1, 0, 0, 4'h0, 32'h0);
        add_row(ROW_CALL,  8'h00,         32'h0,        32'd180,  1, 1, 1, 4'h0, 32'h0);
        add_row(ROW_FRAME, OP_PTT_ON,     32'h0,        32'd190,  1, 0, 0, 4'h0, 32'h0);
        add_row(ROW_FRAME, OP_READ_TX,    32'h0,        32'd200,  1, 0, 0, 4'h0, 32'h0);
        add_row(ROW_BYTE,  8'hFF,         32'h0,        32'd210,  1, 0, 0, 4'h0, 32'h0);
        add_row(ROW_CALL,  8'h00,         32'h0,        32'd220,  1, 0, 0, 4'h0, 32'h0);
        add_row(ROW_CALL,  8'h00,         32'h0,        32'd1210, 1, 0, 0, 4'h0, 32'h0);
        add_row(ROW_CALL,  8'h00,         32'h0,        32'd1220, 0, 0, 0, 4'h0, 32'h0);
        add_row(ROW_CALL,  8'h00,         32'h0,        32'd1230, 1, 0, 0, 4'h0, 32'h0);

        foreach (script[i]) begin
            w = '0;
            w.now   = script[i].now;
            w.link  = script[i].link;
            w.tx    = script[i].tx;
            w.split = script[i].split;
            w.mode  = script[i].mode;
            w.bcd   = script[i].bcd;
            typed_on    = script[i].chk;
            typed_reply = script[i].want;
            case (script[i].kind)
                ROW_BYTE: begin
                    w.act = ACT_BYTE;
                    w.rx  = script[i].op;
                    send_word(w);
                end
                ROW_FRAME: begin
                    send_frame(script[i].op, script[i].args, w);
                end
                default: begin
                    w.act = ACT_SERVICE;
                    send_word(w);
                end
            endcase
        end
        typed_on = 1'b0;
        clock_now = 32'd2000;

        run_phase(32'd1, 25, 51, 1'b0);
        run_phase(32'hFFFF_FFFF, 51, 25, 1'b1);
        run_phase($urandom_range(5000, 2), 0, 0, 1'b0);

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (100) @(posedge aclk);
        if (fault_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
